[sv/circular_fifo_with_remove_by_value_defines.svh]
// Assertion macros used by the checker of the circular FIFO block.
`ifndef CIRCULAR_FIFO_WITH_REMOVE_BY_VALUE_DEFINES_SVH
`define CIRCULAR_FIFO_WITH_REMOVE_BY_VALUE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define CFRV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cfrv assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define CFRV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cfrv assertion failed");

`endif

[sv/cfrv_pkg.sv]
package cfrv_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 4;

    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_mode MODE_ENQ = 2'd0;
    localparam t_mode MODE_DEQ = 2'd1;
    localparam t_mode MODE_REM = 2'd2;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_EMPTY    = 2'd2;
    localparam t_status ST_NOTFOUND = 2'd3;

endpackage

[sv/cfrv_ram.sv]
module cfrv_ram #(
    parameter int WIDTH = cfrv_pkg::DATA_W,
    parameter int DEPTH = cfrv_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/circular_fifo_with_remove_by_value.sv]
// Ring-buffer FIFO of DEPTH signed 32-bit words with remove-by-value. Each input
// transfer carries a mode (enqueue, dequeue, remove first match) and a value, and
// yields exactly one result transfer with data, status and occupancy (low 4 bits
// of the fill count). Words live in a single-port-write, single-port-read RAM with
// registered read data, so cost is set by RAM accesses: enqueue, full, empty and
// unused-mode items go from idle straight to the done state, a dequeue first reads
// the head in S_DEQ, and a remove scans from the head in S_SRCH until it finds its
// match or passes the last word, then, if the match is not the last word, moves
// every later word down one slot in S_SHIFT. One item is in work at a time; a
// finished result waits in the output register while the next item is accepted.
module circular_fifo_with_remove_by_value #(
    parameter int DEPTH = cfrv_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [cfrv_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [cfrv_pkg::DATA_W-1:0]  i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [cfrv_pkg::DATA_W-1:0]  o_data_out,
    output logic [cfrv_pkg::STATUS_W-1:0]       o_status,
    output logic [cfrv_pkg::OCC_W-1:0]          o_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = cfrv_pkg::DATA_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEQ   = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]              r_state,  n_state;
    logic [AW-1:0]           r_head,   n_head;
    logic [AW-1:0]           r_tail,   n_tail;
    logic [CW-1:0]           r_count,  n_count;
    logic [AW-1:0]           r_p,      n_p;
    logic [CW-1:0]           r_i,      n_i;
    logic [DW-1:0]           r_val,    n_val;
    logic [DW-1:0]           r_res_data,   n_res_data;
    cfrv_pkg::t_status       r_res_status, n_res_status;
    logic                    r_out_valid,  n_out_valid;
    logic [DW-1:0]           r_out_data,   n_out_data;
    cfrv_pkg::t_status       r_out_status, n_out_status;
    logic [CW-1:0]           r_out_count,  n_out_count;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [DW-1:0]           ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [DW-1:0]           ram_rdata;

    logic                    in_xfer;
    logic                    last_pos;
    logic                    more_shift;
    logic [AW-1:0]           p_inc;
    logic [AW-1:0]           p_inc2;
    logic [CW+3:0]           occ_ext;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(DEPTH - 1) : a - 1'b1;
    endfunction

    cfrv_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign p_inc      = f_inc(r_p);
    assign p_inc2     = f_inc(p_inc);
    // r_i is the ring offset of r_p from the head
    assign last_pos   = (({1'b0, r_i} + (CW+1)'(1)) == {1'b0, r_count});
    assign more_shift = (({1'b0, r_i} + (CW+1)'(2)) <  {1'b0, r_count});

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_p          = r_p;
        n_i          = r_i;
        n_val        = r_val;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_waddr    = r_p;
        ram_wdata    = ram_rdata;
        ram_raddr    = p_inc;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_val        = i_value;
                    n_res_data   = '0;
                    n_res_status = cfrv_pkg::ST_OK;
                    n_state      = S_DONE;
                    case (i_mode)
                        cfrv_pkg::MODE_ENQ: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_res_status = cfrv_pkg::ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_tail;
                                ram_wdata = i_value;
                                n_tail    = f_inc(r_tail);
                                n_count   = r_count + 1'b1;
                            end
                        end
                        cfrv_pkg::MODE_DEQ: begin
                            if (r_count == '0) begin
                                n_res_data   = '1;
                                n_res_status = cfrv_pkg::ST_EMPTY;
                            end else begin
                                ram_raddr = r_head;
                                n_state   = S_DEQ;
                            end
                        end
                        cfrv_pkg::MODE_REM: begin
                            if (r_count == '0) begin
                                n_res_status = cfrv_pkg::ST_EMPTY;
                            end else begin
                                ram_raddr = r_head;
                                n_p       = r_head;
                                n_i       = '0;
                                n_state   = S_SRCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DEQ: begin
                n_res_data = ram_rdata;
                n_head     = f_inc(r_head);
                n_count    = r_count - 1'b1;
                n_state    = S_DONE;
            end
            S_SRCH: begin
                // ram_rdata holds slot r_p; slot r_p+1 is being fetched
                if (ram_rdata == r_val) begin
                    if (last_pos) begin
                        n_tail  = f_dec(r_tail);
                        n_count = r_count - 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (last_pos) begin
                    n_res_status = cfrv_pkg::ST_NOTFOUND;
                    n_state      = S_DONE;
                end else begin
                    n_p = p_inc;
                    n_i = r_i + 1'b1;
                end
            end
            S_SHIFT: begin
                // move slot r_p+1 down to r_p, fetch r_p+2 for the next move
                ram_we    = 1'b1;
                ram_waddr = r_p;
                ram_wdata = ram_rdata;
                ram_raddr = p_inc2;
                n_p       = p_inc;
                n_i       = r_i + 1'b1;
                if (!more_shift) begin
                    n_tail  = f_dec(r_tail);
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = r_res_data;
                    n_out_status = r_res_status;
                    n_out_count  = r_count;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p          <= n_p;
        r_i          <= n_i;
        r_val        <= n_val;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign occ_ext     = {4'b0000, r_out_count};
    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;
    assign o_status    = r_out_status;
    assign o_occupancy = occ_ext[cfrv_pkg::OCC_W-1:0];

endmodule

[sv/cfrv_checker.sv]
`include "circular_fifo_with_remove_by_value_defines.svh"

module cfrv_props (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [cfrv_pkg::DATA_W-1:0]  o_data_out,
    input logic [cfrv_pkg::STATUS_W-1:0]       o_status,
    input logic [cfrv_pkg::OCC_W-1:0]          o_occupancy
);

    logic empty_status;
    logic no_data_status;

    assign empty_status   = (o_status == cfrv_pkg::ST_EMPTY);
    assign no_data_status = o_status inside {cfrv_pkg::ST_FULL, cfrv_pkg::ST_NOTFOUND};

    // a pending result is not dropped
    `CFRV_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_data_out))

    // one item at a time: ready falls after every input transfer
    `CFRV_ASSERT_NEXT(a_one_in_flight, i_in_valid && o_in_ready, !o_in_ready)

    // an empty report always leaves the queue empty
    `CFRV_ASSERT_NOW(a_empty_occ, o_out_valid && empty_status, o_occupancy == '0)

    // only a successful dequeue or an empty dequeue returns data
    `CFRV_ASSERT_NOW(a_full_data, o_out_valid && no_data_status, o_data_out == '0)

endmodule

bind circular_fifo_with_remove_by_value cfrv_props u_cfrv_props (.*);
